@@ design/slum_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the
// sorted list union merge block. No dependencies.
`default_nettype none

package slum_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int KIND_W = 2;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [KIND_W-1:0] KIND_LOAD_A = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_LOAD_B = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_RUN    = KIND_W'(2);

	// Commands from the controller to the datapath; at most one is high.
	typedef struct packed {
		logic load_a;
		logic load_b;
		logic start;
		logic step;
		logic emit_last;
		logic emit_empty;
	} slum_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic both_empty;
		logic walk_done;
		logic need_emit;
		logic out_free;
	} slum_sts_t;

endpackage

`default_nettype wire

@@ design/slum_in_if.sv @@
// Input channel of the union merge block: valid/ready plus one input word.
// Depends on slum_pkg.
`default_nettype none

interface slum_in_if;
	import slum_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

@@ design/slum_out_if.sv @@
// Output channel of the union merge block: valid/ready plus one result word.
// Depends on slum_pkg.
`default_nettype none

interface slum_out_if;
	import slum_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value_res;
	logic                     last;
	logic                     empty_res;

	modport source (output valid, output value_res, output last, output empty_res,
		input ready);
	modport sink   (input valid, input value_res, input last, input empty_res,
		output ready);
endinterface

`default_nettype wire

@@ design/slum_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module slum_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                          rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/slum_ctrl.sv @@
// Controller state machine of the union merge block: accepts input words,
// sequences the merge walk and the final result. Depends on slum_pkg.
`default_nettype none

module slum_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [slum_pkg::KIND_W-1:0] in_kind,
	output      logic                      in_ready,
	input  wire slum_pkg::slum_sts_t       sts,
	output      slum_pkg::slum_cmd_t       cmd
);
	import slum_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_CMP   = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_EMPTY = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_kind)
						KIND_LOAD_A: cmd.load_a = 1'b1;
						KIND_LOAD_B: cmd.load_b = 1'b1;
						KIND_RUN: begin
							cmd.start = 1'b1;
							state_d   = sts.both_empty ? ST_EMPTY : ST_READ;
						end
						default: ;
					endcase
				end
			end
			// The store read is registered; data for the current pointers is valid in ST_CMP.
			ST_READ: begin
				state_d = sts.walk_done ? ST_FIN : ST_CMP;
			end
			ST_CMP: begin
				if (!sts.need_emit || sts.out_free) begin
					cmd.step = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ design/slum_dp.sv @@
// Datapath of the union merge block: list stores, counts, merge pointers,
// the pending result and the output register. Depends on slum_pkg, slum_ram.
`default_nettype none

module slum_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire slum_pkg::slum_cmd_t             cmd,
	input  wire logic signed [slum_pkg::DATA_W-1:0] in_value,
	output      slum_pkg::slum_sts_t             sts,
	input  wire logic                            out_ready,
	output      logic                            out_valid,
	output      logic signed [slum_pkg::DATA_W-1:0] out_value,
	output      logic                            out_last,
	output      logic                            out_empty
);
	import slum_pkg::*;

	logic [CNT_W-1:0]         cnt_a_q, cnt_b_q;
	logic [CNT_W-1:0]         ptr_a_q, ptr_b_q;
	logic signed [DATA_W-1:0] pend_q;
	logic                     have_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     out_last_q;
	logic                     out_empty_q;

	logic [DATA_W-1:0]        rd_a, rd_b;
	logic signed [DATA_W-1:0] x, y, cand;
	logic                     a_full, b_full, a_has, b_has;
	logic                     x_lt_y, y_lt_x, take_a, take_b, is_new;
	logic                     out_free, out_load;

	slum_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
		.clk    (clk),
		.we     (cmd.load_a && !a_full),
		.waddr  (cnt_a_q[ADDR_W-1:0]),
		.wdata  (in_value),
		.raddr  (ptr_a_q[ADDR_W-1:0]),
		.rdata_q(rd_a)
	);

	slum_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
		.clk    (clk),
		.we     (cmd.load_b && !b_full),
		.waddr  (cnt_b_q[ADDR_W-1:0]),
		.wdata  (in_value),
		.raddr  (ptr_b_q[ADDR_W-1:0]),
		.rdata_q(rd_b)
	);

	always_comb begin
		a_full = (cnt_a_q == CNT_W'(DEPTH));
		b_full = (cnt_b_q == CNT_W'(DEPTH));
		a_has  = (ptr_a_q < cnt_a_q);
		b_has  = (ptr_b_q < cnt_b_q);
		x      = rd_a;
		y      = rd_b;
		x_lt_y = (x < y);
		y_lt_x = (y < x);
		// On equal heads both pointers advance and one copy is kept.
		take_a = a_has && (!b_has || !y_lt_x);
		take_b = b_has && (!a_has || !x_lt_y);
		cand   = take_a ? x : y;
		is_new = !have_q || (cand != pend_q);
		out_free = !out_valid_q || out_ready;
		out_load = (cmd.step && have_q && (cand != pend_q)) || cmd.emit_last
			|| cmd.emit_empty;

		sts.both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
		sts.walk_done  = !a_has && !b_has;
		sts.need_emit  = have_q && (cand != pend_q);
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ptr_a_q     <= '0;
			ptr_b_q     <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_a && !a_full) begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			end
			if (cmd.load_b && !b_full) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			end
			if (cmd.emit_last) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
			end
			if (cmd.start) begin
				ptr_a_q <= '0;
				ptr_b_q <= '0;
				have_q  <= 1'b0;
			end
			if (cmd.step) begin
				if (take_a) begin
					ptr_a_q <= ptr_a_q + CNT_W'(1);
				end
				if (take_b) begin
					ptr_b_q <= ptr_b_q + CNT_W'(1);
				end
				if (is_new) begin
					have_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && is_new) begin
			pend_q <= cand;
		end
		if (cmd.emit_empty) begin
			out_value_q <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
		end else if (out_load) begin
			out_value_q <= pend_q;
			out_last_q  <= cmd.emit_last;
			out_empty_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign out_empty = out_empty_q;

endmodule

`default_nettype wire

@@ design/sorted_list_union_merge.sv @@
// Top level of the sorted list union merge block.
// Depends on slum_pkg, slum_in_if, slum_out_if, slum_ctrl, slum_dp.
//
// Usage: the input channel carries one word per handshake with a kind and
// a value. Kind LOAD_A and LOAD_B append the value to list A or list B;
// loads stream at one word per cycle while no run is in progress. A load
// into a full list (DEPTH entries) is dropped, and kind 3 is ignored.
// A RUN word merges both lists, which should be ascending, and sends every
// distinct value once, in ascending order, on the output channel, with last
// set on the final word. If both lists are empty, one word with empty_res
// and last set and value_res zero is sent. The counts clear after the run.
// Each step of the merge walk is a registered read of the two list stores
// and then a compare, and input ready stays low while a run is in progress.
// A result leaves when the next distinct value is found, or at the end of
// the walk for the last one. Output stalls hold the walk at the compare.
// Reset clears the counts, pointers and control state; the store contents
// are undefined until loaded. The output is registered, so a waiting result
// never blocks loading of the next lists.
`default_nettype none

module sorted_list_union_merge (
	input wire logic   clk,
	input wire logic   arst_n,
	slum_in_if.sink    items,
	slum_out_if.source results
);
	import slum_pkg::*;

	slum_cmd_t cmd;
	slum_sts_t sts;

	// Sequencing of loads, the merge walk and result emission.
	slum_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(items.valid),
		.in_kind (items.kind),
		.in_ready(items.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Stores, pointers, dedup register and output register.
	slum_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_value (items.value),
		.sts      (sts),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.out_value(results.value_res),
		.out_last (results.last),
		.out_empty(results.empty_res)
	);

`ifndef ASSERT_OFF
	// The controller never issues two datapath commands at once.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in one cycle");

	// An accepted run makes the block busy in the next cycle.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && (items.kind == KIND_RUN)) |=> !items.ready)
		else $error("input still ready after a run was accepted");

	// The empty marker only appears on the final word of a run.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.empty_res) |-> results.last)
		else $error("empty result without last");
`endif

endmodule

`default_nettype wire

@@ verif/tb_sorted_list_union_merge.sv @@
// Self-checking testbench for the sorted list union merge block: directed and random
// load/run words, a scoreboard of predicted union words, random stalls on both channels.
// Depends on slum_pkg, slum_in_if, slum_out_if and sorted_list_union_merge.
`default_nettype none

module tb_sorted_list_union_merge;
	timeunit 1ns;
	timeprecision 1ps;

	import slum_pkg::*;

	// Kind 3 has no meaning in the block; it must be swallowed without effect.
	localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_W'(3);

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	localparam int RANDOM_WORDS  = 215;
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
	localparam int SETTLE_CYCLES = 200;   // well above the longest merge walk
	localparam int MAX_REPORTS   = 40;
	localparam int TIMEOUT_NS    = 2_000_000;

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef elem_t elem_q_t[$];

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		elem_t             value;
	} item_word_t;

	typedef struct packed {
		elem_t value;
		logic  last;
		logic  empty;
	} union_word_t;

	logic clk = 1'b0;
	logic arst_n;

	slum_in_if  items();
	slum_out_if results();

	sorted_list_union_merge DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results)
	);

	// Mirror of the two list stores and their fill counts.
	elem_t a_entries [DEPTH];
	elem_t b_entries [DEPTH];
	int    fill_a = 0;
	int    fill_b = 0;

	// Words still to be offered, and union words predicted but not yet seen.
	item_word_t  pending_q [$];
	union_word_t union_q [$];
	item_word_t  offer_word;
	union_word_t exp_word;

	int total_words   = 0;
	int n_accepted    = 0;
	int n_runs        = 0;
	int n_empty_runs  = 0;
	int n_dropped     = 0;
	int n_ignored     = 0;
	int n_results     = 0;
	int n_errors      = 0;
	int longest_union = 0;
	int stall_cycles  = 0;
	int hold_left;
	bit hold_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one accepted input word to the mirrored state. A run walks both
	// lists with two indexes and queues every value that differs from the one
	// queued just before it; the final word of the run carries last.
	task automatic predict_word(input logic [KIND_W-1:0] kind, input elem_t value);
		union_word_t run_q [$];
		int          ia;
		int          ib;
		elem_t       cand;
		elem_t       prev;
		bit          have;
		ia   = 0;
		ib   = 0;
		have = 1'b0;
		prev = '0;
		case (kind)
			KIND_LOAD_A: begin
				if (fill_a < DEPTH) begin
					a_entries[fill_a] = value;
					fill_a++;
				end else begin
					n_dropped++;
				end
			end
			KIND_LOAD_B: begin
				if (fill_b < DEPTH) begin
					b_entries[fill_b] = value;
					fill_b++;
				end else begin
					n_dropped++;
				end
			end
			KIND_RUN: begin
				n_runs++;
				if (fill_a == 0 && fill_b == 0) begin
					n_empty_runs++;
					run_q.push_back('{value: '0, last: 1'b1, empty: 1'b1});
				end else begin
					while (ia < fill_a || ib < fill_b) begin
						if (ia < fill_a && ib < fill_b) begin
							if (a_entries[ia] < b_entries[ib]) begin
								cand = a_entries[ia];
								ia++;
							end else if (b_entries[ib] < a_entries[ia]) begin
								cand = b_entries[ib];
								ib++;
							end else begin
								cand = a_entries[ia];
								ia++;
								ib++;
							end
						end else if (ia < fill_a) begin
							cand = a_entries[ia];
							ia++;
						end else begin
							cand = b_entries[ib];
							ib++;
						end
						if (!have || cand != prev) begin
							run_q.push_back('{value: cand, last: 1'b0, empty: 1'b0});
							prev = cand;
							have = 1'b1;
						end
					end
					run_q[run_q.size()-1].last = 1'b1;
				end
				fill_a = 0;
				fill_b = 0;
				if (run_q.size() > longest_union)
					longest_union = run_q.size();
				foreach (run_q[i])
					union_q.push_back(run_q[i]);
			end
			default: begin
				n_ignored++;
			end
		endcase
	endtask

	task automatic add_word(input logic [KIND_W-1:0] kind, input elem_t value);
		pending_q.push_back('{kind: kind, value: value});
	endtask

	// Builds one list. Most lists are ascending, either dense with many repeats
	// or spread over the whole signed range and clamped at the top; some are
	// unsorted. A few run past the store depth so that loads get dropped.
	task automatic make_list(output elem_q_t lst);
		int     n;
		int     style;
		int     r;
		longint cur;
		lst   = {};
		r     = $urandom_range(0, 99);
		n     = (r < 80) ? $urandom_range(0, 8) :
		        (r < 95) ? $urandom_range(9, DEPTH) : $urandom_range(DEPTH + 1, DEPTH + 4);
		style = $urandom_range(0, 99);
		if (style < 60)
			cur = longint'($urandom_range(0, 40)) - 20;
		else
			cur = longint'($signed($urandom));
		for (int i = 0; i < n; i++) begin
			if (style < 15) begin
				if ($urandom_range(0, 1))
					lst.push_back(elem_t'($urandom));
				else
					lst.push_back(elem_t'(int'($urandom_range(0, 6)) - 3));
			end else begin
				lst.push_back(elem_t'(cur));
				if (style < 60)
					cur += $urandom_range(0, 3);
				else
					cur += $urandom_range(0, 32'h1000_0000);
				if (cur > longint'(VAL_MAX))
					cur = longint'(VAL_MAX);
			end
		end
	endtask

	// Idle share in percent for either side. The run is split in thirds by
	// accepted words: sender light and receiver heavy, then the reverse, then
	// both sides at full rate.
	function automatic int idle_pct(input bit receiver);
		int phase;
		phase = (total_words == 0) ? 0 : (n_accepted * 3) / total_words;
		case (phase)
			0:       return receiver ? 55 : 29;
			1:       return receiver ? 29 : 55;
			default: return 0;
		endcase
	endfunction

	// Sender. A word leaves the pending queue when it is put on the channel and
	// is handed to the predictor at the edge where the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items.valid <= 1'b0;
		end else begin
			if (items.valid && items.ready) begin
				predict_word(items.kind, items.value);
				n_accepted <= n_accepted + 1;
			end
			if (!items.valid || items.ready) begin
				if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
					offer_word = pending_q.pop_front();
					items.valid <= 1'b1;
					items.kind  <= offer_word.kind;
					items.value <= offer_word.value;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// One long hold-off on the result side, started a sixth of the way in while
	// the sender keeps offering, so that a run backs up and stalls the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= total_words / 6) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			if (items.valid && !items.ready)
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Receiver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			results.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
		end
	end

	// Result checker: every accepted result word is matched against the oldest
	// predicted union word, field by field.
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			n_results++;
			if (union_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$error("unexpected result word: value_res %0d last %0b empty_res %0b",
						results.value_res, results.last, results.empty_res);
			end else begin
				exp_word = union_q.pop_front();
				if (results.value_res !== exp_word.value) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$error("value_res: expected %0d, got %0d",
							exp_word.value, results.value_res);
				end
				if (results.last !== exp_word.last) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$error("last: expected %0b, got %0b", exp_word.last, results.last);
				end
				if (results.empty_res !== exp_word.empty) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$error("empty_res: expected %0b, got %0b",
							exp_word.empty, results.empty_res);
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		elem_q_t la;
		elem_q_t lb;
		int      counted;
		items.valid   = 1'b0;
		items.kind    = KIND_LOAD_A;
		items.value   = '0;
		results.ready = 1'b0;
		arst_n        = 1'b0;

		// A run with nothing loaded gives the single empty word.
		add_word(KIND_RUN, VAL_MAX);
		// Extremes of the signed range in both lists, shared ends collapse, and
		// an unused kind in the middle of the loads changes nothing.
		add_word(KIND_LOAD_A, VAL_MIN);
		add_word(KIND_LOAD_A, -1);
		add_word(KIND_LOAD_A, 0);
		add_word(KIND_LOAD_A, VAL_MAX);
		add_word(KIND_LOAD_B, VAL_MIN);
		add_word(KIND_UNUSED, VAL_MAX);
		add_word(KIND_LOAD_B, 5);
		add_word(KIND_LOAD_B, VAL_MAX);
		add_word(KIND_RUN, '0);
		// Only list A, then only list B with a repeat inside the list.
		add_word(KIND_LOAD_A, 7);
		add_word(KIND_RUN, -1);
		add_word(KIND_LOAD_B, -3);
		add_word(KIND_LOAD_B, -3);
		add_word(KIND_LOAD_B, 2);
		add_word(KIND_RUN, 0);
		// Counts are clear again: an ignored word then a run is still empty.
		add_word(KIND_UNUSED, VAL_MIN);
		add_word(KIND_RUN, 0);
		// Unsorted lists: the merge only compares the list heads as they come.
		add_word(KIND_LOAD_A, 5);
		add_word(KIND_LOAD_A, 1);
		add_word(KIND_LOAD_B, 3);
		add_word(KIND_LOAD_B, 5);
		add_word(KIND_LOAD_B, 1);
		add_word(KIND_RUN, 0);

		// Random part: two lists with their loads interleaved at random, a few
		// ignored words sprinkled in, then a run with a junk value.
		counted = 0;
		while (counted < RANDOM_WORDS) begin
			make_list(la);
			make_list(lb);
			while (la.size() > 0 || lb.size() > 0) begin
				if ($urandom_range(0, 99) < 4)
					add_word(KIND_UNUSED, $urandom);
				if (lb.size() == 0 || (la.size() > 0 && $urandom_range(0, 1)))
					add_word(KIND_LOAD_A, la.pop_front());
				else
					add_word(KIND_LOAD_B, lb.pop_front());
				counted++;
			end
			add_word(KIND_RUN, $urandom);
			counted++;
		end
		total_words = pending_q.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Everything offered and taken, then every predicted word seen.
		while (pending_q.size() > 0 || items.valid)
			@(posedge clk);
		while (union_q.size() > 0)
			@(posedge clk);
		// Loads after the last run have no result; give the block time to show
		// any stray word before deciding.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d words: %0d merges (%0d empty), %0d dropped loads,",
			n_accepted, n_runs, n_empty_runs, n_dropped);
		$display("%0d unused kinds, %0d results, longest union %0d, %0d stalls in hold-off.",
			n_ignored, n_results, longest_union, stall_cycles);
		if (n_errors == 0)
			$display("tb_sorted_list_union_merge passed");
		else
			$display("tb_sorted_list_union_merge failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$error("timeout: %0d words still pending, %0d results outstanding",
			pending_q.size(), union_q.size());
		$display("tb_sorted_list_union_merge failed");
		$finish;
	end

endmodule

`default_nettype wire
